[rtl/glp_pkg.sv]
// Shared types, character codes and constant tables for the G-code line parser.
// Used by the controller, the datapath, the top level and the port checker.
`timescale 1ns / 1ps

package glp_pkg;

  localparam int unsigned WORD_SLOTS_DEF = 8;
  localparam int unsigned AXIS_SCALE_DEF = 1000;

  // Character codes.
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] CH_X     = 8'h58;
  localparam logic [7:0] CH_Y     = 8'h59;
  localparam logic [7:0] CH_F     = 8'h46;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_M     = 8'h4D;
  localparam logic [7:0] CASE_FOLD_MASK = 8'hDF;

  localparam logic [3:0] MAX_DECIMALS = 4'd10;

  // Line status codes.
  localparam logic [1:0] ST_CONT = 2'd0;
  localparam logic [1:0] ST_OK   = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  // Command kind codes.
  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_MOVE   = 2'd1;
  localparam logic [1:0] KIND_REPORT = 2'd2;

  localparam logic [31:0] POW10 [10] = '{
    32'd1, 32'd10, 32'd100, 32'd1000, 32'd10000, 32'd100000, 32'd1000000,
    32'd10000000, 32'd100000000, 32'd1000000000
  };

  typedef struct packed {
    logic [7:0]  letter;
    logic [31:0] mant;
    logic [3:0]  dec;
    logic        neg;
  } word_t;

  typedef struct packed {
    logic [31:0] mult;
    logic [3:0]  e;
  } scale_ent_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take_char;
    logic mul;
    logic round;
    logic div_step;
    logic apply;
    logic next_slot;
    logic emit_line;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic convert_req;
    logic slot_done;
    logic relevant;
    logic e_zero;
    logic div_last;
    logic out_free;
  } sts_t;

  // Cancels common factors of ten between the scale and the fraction digits.
  // Evaluated at elaboration only.
  function automatic scale_ent_t strip_scale(input int unsigned scale, input int unsigned e);
    int unsigned m;
    int unsigned k;
    scale_ent_t  r;
    m = scale;
    k = e;
    for (int i = 0; i < 9; i++) begin
      if (k != 0 && (m % 10) == 0) begin
        m = m / 10;
        k = k - 1;
      end
    end
    r.mult = m[31:0];
    r.e    = k[3:0];
    return r;
  endfunction

endpackage

[rtl/glp_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module glp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/glp_ctrl.sv]
// Controller of the G-code line parser: takes characters and sequences the
// line-end conversion. Depends on glp_pkg.
`timescale 1ns / 1ps

module glp_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          char_in_valid_i,
  output logic          char_in_ready_o,
  input  glp_pkg::sts_t sts_i,
  output glp_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CHECK,
    S_ROUND,
    S_DIV,
    S_APPLY,
    S_FINISH
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign char_in_ready_o = (state_q == S_IDLE) && sts_i.out_free;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (char_in_valid_i && char_in_ready_o) begin
          cmd_o.take_char = 1'b1;
          if (sts_i.convert_req) begin
            state_d = S_READ;
          end
        end
      end
      S_READ: begin
        // The RAM address follows the slot pointer; data arrives next cycle.
        state_d = sts_i.slot_done ? S_FINISH : S_CHECK;
      end
      S_CHECK: begin
        if (sts_i.relevant) begin
          cmd_o.mul = 1'b1;
          state_d   = S_ROUND;
        end else begin
          cmd_o.next_slot = 1'b1;
          state_d         = S_READ;
        end
      end
      S_ROUND: begin
        if (sts_i.e_zero) begin
          state_d = S_APPLY;
        end else begin
          cmd_o.round = 1'b1;
          state_d     = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_APPLY;
        end
      end
      S_APPLY: begin
        cmd_o.apply = 1'b1;
        state_d     = S_READ;
      end
      S_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.emit_line = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

[rtl/glp_datapath.sv]
// Datapath of the G-code line parser: word assembly, word store, scaling,
// rounding divider, sticky targets and the result register. Depends on
// glp_pkg and glp_ram.
`timescale 1ns / 1ps

module glp_datapath #(
  parameter int unsigned WordSlots = glp_pkg::WORD_SLOTS_DEF,
  parameter int unsigned AxisScale = glp_pkg::AXIS_SCALE_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  glp_pkg::cmd_t      cmd_i,
  output glp_pkg::sts_t      sts_o,
  input  logic [7:0]         char_in_i,
  input  logic               cfg_we_i,
  input  logic [30:0]        cfg_wdata_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [1:0]         line_status_o,
  output logic [1:0]         command_kind_o,
  output logic signed [31:0] target_x_o,
  output logic signed [31:0] target_y_o,
  output logic signed [31:0] target_feed_o
);

  localparam int unsigned AW = $clog2(WordSlots);
  localparam int unsigned IW = $clog2(WordSlots + 1);

  typedef enum logic [1:0] {
    MODE_LETTER,
    MODE_NUMBER,
    MODE_DIGITS,
    MODE_ERROR
  } mode_e;

  typedef enum logic [1:0] {
    SEL_X,
    SEL_Y,
    SEL_F
  } sel_e;

  mode_e          mode_q, mode_d;
  logic [IW-1:0]  idx_q, idx_d;
  glp_pkg::word_t cur_q, cur_d;
  logic [7:0]     cmd_letter_q, cmd_letter_d;
  logic [IW-1:0]  slot_q, n_q;
  logic [1:0]     kind_q;

  logic           ram_we;
  glp_pkg::word_t ram_rdata;

  logic [7:0] ch, folded;
  logic       is_end, is_white, is_num, is_upper;
  logic [31:0] mant_step;

  // Conversion registers.
  logic [31:0] prod_q;
  logic [3:0]  e_q;
  logic        neg_q;
  sel_e        sel_q;
  logic [31:0] div_q, divisor_q, rem_q;
  logic [4:0]  cnt_q;

  logic [31:0] sticky_x_q, sticky_y_q, sticky_feed_q;

  // Scale table for the axes, folded at elaboration.
  logic [31:0] ax_mult [10];
  logic [3:0]  ax_e    [10];

  for (genvar g = 0; g < 10; g++) begin : g_tab
    glp_pkg::scale_ent_t ent;
    assign ent        = glp_pkg::strip_scale(AxisScale, g);
    assign ax_mult[g] = ent.mult;
    assign ax_e[g]    = ent.e;
  end

  glp_ram #(
    .Width ($bits(glp_pkg::word_t)),
    .Depth (WordSlots)
  ) u_word_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q[AW-1:0]),
    .wdata_i (cur_q),
    .raddr_i (slot_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Character classes.
  always_comb begin
    ch       = char_in_i;
    folded   = (ch >= glp_pkg::CH_LO_A && ch <= glp_pkg::CH_LO_Z) ?
               (ch & glp_pkg::CASE_FOLD_MASK) : ch;
    is_end   = (ch == glp_pkg::CH_LF) || (ch == glp_pkg::CH_CR);
    is_white = (ch == glp_pkg::CH_SPACE) || (ch == glp_pkg::CH_TAB);
    is_num   = (ch >= glp_pkg::CH_ZERO) && (ch <= glp_pkg::CH_NINE);
    is_upper = (folded >= glp_pkg::CH_UP_A) && (folded <= glp_pkg::CH_UP_Z);
    mant_step = {cur_q.mant[28:0], 3'b000} + {cur_q.mant[30:0], 1'b0} +
                {28'd0, ch[3:0]};
  end

  // Word assembly.
  always_comb begin
    mode_d       = mode_q;
    idx_d        = idx_q;
    cur_d        = cur_q;
    cmd_letter_d = cmd_letter_q;
    ram_we       = 1'b0;
    if (cmd_i.take_char) begin
      if (is_end) begin
        ram_we = (mode_q == MODE_DIGITS);
        mode_d = MODE_LETTER;
        idx_d  = '0;
      end else begin
        case (mode_q)
          MODE_LETTER: begin
            if (!is_white) begin
              if (is_upper && idx_q < IW'(WordSlots)) begin
                cur_d = '{letter: folded, mant: 32'd0, dec: 4'd0, neg: 1'b0};
                if (idx_q == '0) begin
                  cmd_letter_d = folded;
                end
                mode_d = MODE_NUMBER;
              end else begin
                mode_d = MODE_ERROR;
              end
            end
          end
          MODE_NUMBER, MODE_DIGITS: begin
            if (mode_q == MODE_NUMBER) begin
              mode_d = MODE_DIGITS;
            end
            if (is_num) begin
              if (cur_q.dec >= glp_pkg::MAX_DECIMALS) begin
                mode_d = MODE_ERROR;
              end else begin
                cur_d.mant = mant_step;
                if (cur_q.dec != 4'd0) begin
                  cur_d.dec = cur_q.dec + 4'd1;
                end
              end
            end else if (mode_q == MODE_NUMBER && ch == glp_pkg::CH_MINUS) begin
              cur_d.neg = 1'b1;
            end else if (mode_q == MODE_DIGITS && is_white) begin
              ram_we = 1'b1;
              mode_d = MODE_LETTER;
              idx_d  = idx_q + IW'(1);
            end else if (mode_q == MODE_DIGITS && ch == glp_pkg::CH_DOT) begin
              cur_d.dec = 4'd1;
            end else begin
              mode_d = MODE_ERROR;
            end
          end
          MODE_ERROR: begin
            mode_d = MODE_ERROR;
          end
          default: begin
            mode_d = MODE_ERROR;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_LETTER;
      idx_q  <= '0;
      slot_q <= '0;
      n_q    <= '0;
    end else begin
      mode_q <= mode_d;
      idx_q  <= idx_d;
      if (cmd_i.take_char && sts_o.convert_req) begin
        slot_q <= IW'(1);
        n_q    <= idx_q;
      end else if (cmd_i.apply || cmd_i.next_slot) begin
        slot_q <= slot_q + IW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q        <= cur_d;
    cmd_letter_q <= cmd_letter_d;
    if (cmd_i.take_char && sts_o.convert_req) begin
      if (cmd_letter_q == glp_pkg::CH_G) begin
        kind_q <= glp_pkg::KIND_MOVE;
      end else if (cmd_letter_q == glp_pkg::CH_M) begin
        kind_q <= glp_pkg::KIND_REPORT;
      end else begin
        kind_q <= glp_pkg::KIND_NONE;
      end
    end
  end

  // Scaling, rounding and the restoring divider.
  logic [3:0]  e_raw, e_idx;
  logic [31:0] rem_sh;
  logic        rem_ge;
  logic [31:0] mag, signed_val;

  always_comb begin
    e_raw  = (ram_rdata.dec == 4'd0) ? 4'd0 : ram_rdata.dec - 4'd1;
    e_idx  = (e_raw > 4'd9) ? 4'd9 : e_raw;
    rem_sh = {rem_q[30:0], div_q[31]};
    rem_ge = (rem_sh >= divisor_q);
    mag    = (e_q == 4'd0) ? prod_q : div_q;
    signed_val = neg_q ? (32'd0 - mag) : mag;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      neg_q <= ram_rdata.neg;
      if (ram_rdata.letter == glp_pkg::CH_F) begin
        sel_q  <= SEL_F;
        prod_q <= ram_rdata.mant;
        e_q    <= e_idx;
      end else begin
        sel_q  <= (ram_rdata.letter == glp_pkg::CH_X) ? SEL_X : SEL_Y;
        prod_q <= ram_rdata.mant * ax_mult[e_idx];
        e_q    <= ax_e[e_idx];
      end
    end
    if (cmd_i.round) begin
      div_q     <= prod_q + (glp_pkg::POW10[e_q] >> 1);
      divisor_q <= glp_pkg::POW10[e_q];
      rem_q     <= 32'd0;
      cnt_q     <= 5'd0;
    end else if (cmd_i.div_step) begin
      rem_q <= rem_ge ? (rem_sh - divisor_q) : rem_sh;
      div_q <= {div_q[30:0], rem_ge};
      cnt_q <= cnt_q + 5'd1;
    end
  end

  // Sticky targets.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sticky_x_q    <= '0;
      sticky_y_q    <= '0;
      sticky_feed_q <= '0;
    end else if (cfg_we_i) begin
      sticky_feed_q <= {1'b0, cfg_wdata_i};
    end else if (cmd_i.apply) begin
      case (sel_q)
        SEL_X:   sticky_x_q    <= signed_val;
        SEL_Y:   sticky_y_q    <= signed_val;
        SEL_F:   sticky_feed_q <= signed_val;
        default: sticky_x_q    <= sticky_x_q;
      endcase
    end
  end

  // Result register.
  logic out_valid_q;
  logic load_char;

  assign load_char = cmd_i.take_char && !sts_o.convert_req;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_char || cmd_i.emit_line) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_char) begin
      line_status_o  <= is_end ? glp_pkg::ST_ERR : glp_pkg::ST_CONT;
      command_kind_o <= glp_pkg::KIND_NONE;
      target_x_o     <= sticky_x_q;
      target_y_o     <= sticky_y_q;
      target_feed_o  <= sticky_feed_q;
    end else if (cmd_i.emit_line) begin
      line_status_o  <= glp_pkg::ST_OK;
      command_kind_o <= kind_q;
      target_x_o     <= sticky_x_q;
      target_y_o     <= sticky_y_q;
      target_feed_o  <= sticky_feed_q;
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    sts_o.convert_req = is_end && (mode_q == MODE_DIGITS);
    sts_o.slot_done   = (slot_q > n_q);
    sts_o.relevant    = (ram_rdata.letter == glp_pkg::CH_X) ||
                        (ram_rdata.letter == glp_pkg::CH_Y) ||
                        (ram_rdata.letter == glp_pkg::CH_F);
    sts_o.e_zero      = (e_q == 4'd0);
    sts_o.div_last    = (cnt_q == 5'd31);
    sts_o.out_free    = !out_valid_q || out_ready_i;
  end

endmodule

[rtl/gcode_line_parser_top.sv]
// Top level of the G-code line parser: joins the controller and the datapath.
// Depends on glp_pkg, glp_ctrl, glp_datapath (and glp_ram below it).
`timescale 1ns / 1ps

// The block takes G-code text one byte per request on the char_in channel and
// returns exactly one result request per byte on the out channel. Each result
// carries the line status, the command kind and the current X, Y and feed
// targets. Both channels use valid and ready.
//
// A byte that does not end a line, or a line end that closes a bad line, gives
// its result in the cycle after it is taken. A line end after a good number
// starts the conversion: each stored word after the first is read from the
// word RAM. Letters other than X, Y and F are read, checked and skipped. An X
// or Y word is scaled and an F word is taken as it is; the word is applied
// directly when its fraction digits are all absorbed by factors of ten in the
// scale (for F, when it has none), and otherwise after the rounding division
// by the one-bit-per-cycle restoring divider. The block works on one byte at a
// time; char_in_ready_o is high only while the controller is idle and the
// result register is empty or being drained.
//
// Reset clears the parse state, the targets and the feedrate to zero. Writing
// cfg_we_i loads the initial feedrate into the feed target at once. When the
// receiver stalls, the result register holds its request and no new byte is
// taken until it is accepted.

module gcode_line_parser_top #(
  parameter int unsigned WordSlots = glp_pkg::WORD_SLOTS_DEF,
  parameter int unsigned AxisScale = glp_pkg::AXIS_SCALE_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [30:0]        cfg_wdata_i,
  input  logic               char_in_valid_i,
  output logic               char_in_ready_o,
  input  logic [7:0]         char_in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         line_status_o,
  output logic [1:0]         command_kind_o,
  output logic signed [31:0] target_x_o,
  output logic signed [31:0] target_y_o,
  output logic signed [31:0] target_feed_o
);

  glp_pkg::cmd_t cmd;
  glp_pkg::sts_t sts;

  // The controller owns the input handshake and the conversion sequence.
  glp_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .char_in_valid_i (char_in_valid_i),
    .char_in_ready_o (char_in_ready_o),
    .sts_i           (sts),
    .cmd_o           (cmd)
  );

  // The datapath holds every word, target and the result register.
  glp_datapath #(
    .WordSlots (WordSlots),
    .AxisScale (AxisScale)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .char_in_i      (char_in_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .line_status_o  (line_status_o),
    .command_kind_o (command_kind_o),
    .target_x_o     (target_x_o),
    .target_y_o     (target_y_o),
    .target_feed_o  (target_feed_o)
  );

endmodule

[rtl/glp_checker.sv]
// Port-level checker for the G-code line parser, bound to the top level.
// Depends on glp_pkg.
`timescale 1ns / 1ps

module glp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       char_in_valid_i,
  input logic       char_in_ready_o,
  input logic [7:0] char_in_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] line_status_o,
  input logic [1:0] command_kind_o
);

  // A pending result request is not dropped.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result request dropped while stalled");

  // A command is only issued with a good line end.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && command_kind_o != glp_pkg::KIND_NONE |->
      line_status_o == glp_pkg::ST_OK)
    else $error("command without good line end");

  // A byte that does not end a line gives its result in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    char_in_valid_i && char_in_ready_o &&
      char_in_i != glp_pkg::CH_LF && char_in_i != glp_pkg::CH_CR |=> out_valid_o)
    else $error("missing result for a plain byte");

  // No new byte is taken while a result waits on a stalled receiver.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !char_in_ready_o)
    else $error("byte taken while result stalled");

endmodule

bind gcode_line_parser_top glp_checker u_glp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .char_in_valid_i (char_in_valid_i),
  .char_in_ready_o (char_in_ready_o),
  .char_in_i       (char_in_i),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .line_status_o   (line_status_o),
  .command_kind_o  (command_kind_o)
);
